FILE: rtl/wavp_pkg.sv
// shared types and constants of the riff/wave header parser
package wavp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;
	localparam logic [31:0] FMT_MIN  = 32'd16;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_NOT_WAVE  = 2'd1,
		ERR_FMT_SHORT = 2'd2,
		ERR_EARLY_END = 2'd3
	} err_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_end;
	} in_item_t;

	typedef struct packed {
		logic        header_ok;
		err_t        error_code;
		logic [15:0] audio_format;
		logic [15:0] channel_count;
		logic [31:0] sample_rate;
		logic [15:0] bits_per_sample;
		logic [31:0] data_offset;
		logic [31:0] data_size;
	} result_t;

endpackage

FILE: rtl/wavp_in_reg.sv
// input register stage of the header parser
module wavp_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  wavp_pkg::in_item_t in_item,
	input  logic               advance,
	output logic               valid_s1,
	output wavp_pkg::in_item_t item_s1
);
	import wavp_pkg::*;

	// holding register frees up whenever the parser takes its word
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

endmodule

FILE: rtl/wavp_parser.sv
// parser state and per-byte next-state logic
module wavp_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               consume,
	input  wavp_pkg::in_item_t item,
	output logic               emit,
	output wavp_pkg::result_t  result
);
	import wavp_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_CHUNK  = 3'd1,
		PH_FMT    = 3'd2,
		PH_SKIP   = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [4:0]  fbc_q, fbc_d;
	logic [31:0] skip_q, skip_d;
	logic [31:0] pos_q, pos_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] len_q, len_d;
	logic [15:0] fmt_q, fmt_d;
	logic [15:0] ch_q, ch_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] bits_q, bits_d;
	logic        fmt_seen_q, fmt_seen_d;
	logic        pad_q, pad_d;
	// staging for a fmt body in flight
	logic [15:0] st_fmt_q, st_fmt_d;
	logic [15:0] st_ch_q, st_ch_d;
	logic [31:0] st_rate_q, st_rate_d;
	logic [15:0] st_bits_q, st_bits_d;
	logic [31:0] tag_shift, len_shift;

	assign tag_shift = {item.data_byte, tag_q[31:8]};
	assign len_shift = {item.data_byte, len_q[31:8]};

	always_comb begin
		phase_d    = phase_q;
		fbc_d      = fbc_q;
		skip_d     = skip_q;
		pos_d      = pos_q;
		tag_d      = tag_q;
		len_d      = len_q;
		fmt_d      = fmt_q;
		ch_d       = ch_q;
		rate_d     = rate_q;
		bits_d     = bits_q;
		fmt_seen_d = fmt_seen_q;
		pad_d      = pad_q;
		st_fmt_d   = st_fmt_q;
		st_ch_d    = st_ch_q;
		st_rate_d  = st_rate_q;
		st_bits_d  = st_bits_q;
		emit       = 1'b0;
		result.header_ok       = 1'b0;
		result.error_code      = ERR_NONE;
		result.audio_format    = fmt_q;
		result.channel_count   = ch_q;
		result.sample_rate     = rate_q;
		result.bits_per_sample = bits_q;
		result.data_offset     = '0;
		result.data_size       = '0;
		if (item.stream_end) begin
			if (phase_q == PH_HEADER || phase_q == PH_CHUNK || phase_q == PH_FMT
					|| phase_q == PH_SKIP) begin
				emit              = 1'b1;
				result.error_code = ERR_EARLY_END;
			end
			phase_d    = PH_HEADER;
			fbc_d      = '0;
			skip_d     = '0;
			pos_d      = '0;
			tag_d      = '0;
			len_d      = '0;
			fmt_d      = '0;
			ch_d       = '0;
			rate_d     = '0;
			bits_d     = '0;
			fmt_seen_d = 1'b0;
			pad_d      = 1'b0;
			st_fmt_d   = '0;
			st_ch_d    = '0;
			st_rate_d  = '0;
			st_bits_d  = '0;
		end else begin
			case (phase_q)
				PH_HEADER: begin
					pos_d = pos_q + 32'd1;
					if (fbc_q < 5'd4) begin
						tag_d = tag_shift;
					end else if (fbc_q >= 5'd8) begin
						len_d = len_shift;
					end
					if (fbc_q >= 5'd11) begin
						fbc_d = '0;
						if (tag_d != TAG_RIFF || len_d != TAG_WAVE) begin
							emit              = 1'b1;
							result.error_code = ERR_NOT_WAVE;
							phase_d           = PH_DONE;
						end else begin
							phase_d = PH_CHUNK;
						end
					end else begin
						fbc_d = fbc_q + 5'd1;
					end
				end
				PH_CHUNK: begin
					pos_d = pos_q + 32'd1;
					if (fbc_q < 5'd4) begin
						tag_d = tag_shift;
					end else begin
						len_d = len_shift;
					end
					if (fbc_q < 5'd7) begin
						fbc_d = fbc_q + 5'd1;
					end else begin
						fbc_d = '0;
						if (tag_d == TAG_FMT) begin
							if (len_d < FMT_MIN) begin
								emit              = 1'b1;
								result.error_code = ERR_FMT_SHORT;
								phase_d           = PH_DONE;
							end else begin
								st_fmt_d  = '0;
								st_ch_d   = '0;
								st_rate_d = '0;
								st_bits_d = '0;
								phase_d   = PH_FMT;
							end
						end else if (tag_d == TAG_DATA) begin
							emit               = 1'b1;
							result.header_ok   = fmt_seen_q;
							result.data_offset = pos_d;
							result.data_size   = len_d;
							phase_d            = PH_DONE;
						end else begin
							skip_d  = len_d;
							pad_d   = len_d[0];
							phase_d = (skip_d == '0 && !pad_d) ? PH_CHUNK : PH_SKIP;
						end
					end
				end
				PH_FMT: begin
					pos_d = pos_q + 32'd1;
					// little-endian fields shift in from the top
					if (fbc_q < 5'd2) begin
						st_fmt_d = {item.data_byte, st_fmt_q[15:8]};
					end else if (fbc_q < 5'd4) begin
						st_ch_d = {item.data_byte, st_ch_q[15:8]};
					end else if (fbc_q < 5'd8) begin
						st_rate_d = {item.data_byte, st_rate_q[31:8]};
					end else if (fbc_q >= 5'd14) begin
						st_bits_d = {item.data_byte, st_bits_q[15:8]};
					end
					if (fbc_q < 5'd15) begin
						fbc_d = fbc_q + 5'd1;
					end else begin
						fmt_d      = st_fmt_d;
						ch_d       = st_ch_d;
						rate_d     = st_rate_d;
						bits_d     = st_bits_d;
						fmt_seen_d = 1'b1;
						skip_d     = len_q - FMT_MIN;
						pad_d      = len_q[0];
						fbc_d      = '0;
						phase_d    = (skip_d == '0 && !pad_d) ? PH_CHUNK : PH_SKIP;
					end
				end
				PH_SKIP: begin
					pos_d = pos_q + 32'd1;
					if (skip_q != '0) begin
						skip_d = skip_q - 32'd1;
					end else begin
						pad_d = 1'b0;
					end
					if (skip_d == '0 && !pad_d) begin
						phase_d = PH_CHUNK;
						fbc_d   = '0;
					end
				end
				default: begin
					// finished: bytes are dropped until the stream ends
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			fbc_q      <= '0;
			skip_q     <= '0;
			pos_q      <= '0;
			tag_q      <= '0;
			len_q      <= '0;
			fmt_q      <= '0;
			ch_q       <= '0;
			rate_q     <= '0;
			bits_q     <= '0;
			fmt_seen_q <= 1'b0;
			pad_q      <= 1'b0;
		end else if (consume) begin
			phase_q    <= phase_d;
			fbc_q      <= fbc_d;
			skip_q     <= skip_d;
			pos_q      <= pos_d;
			tag_q      <= tag_d;
			len_q      <= len_d;
			fmt_q      <= fmt_d;
			ch_q       <= ch_d;
			rate_q     <= rate_d;
			bits_q     <= bits_d;
			fmt_seen_q <= fmt_seen_d;
			pad_q      <= pad_d;
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			st_fmt_q  <= st_fmt_d;
			st_ch_q   <= st_ch_d;
			st_rate_q <= st_rate_d;
			st_bits_q <= st_bits_d;
		end
	end

endmodule

FILE: rtl/wavp_out_reg.sv
// result register of the header parser
module wavp_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  wavp_pkg::result_t result_in,
	input  logic              out_stall,
	output logic              out_valid,
	output wavp_pkg::result_t result_q,
	output logic              advance
);
	import wavp_pkg::*;

	// room for a new result when empty or when the held word leaves now
	assign advance = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && advance) begin
			result_q <= result_in;
		end
	end

endmodule

FILE: rtl/wav_riff_header_parser_top.sv
// top level of the riff/wave header parser
// usage:
//   the input channel moves one word per file byte: data_byte plus stream_end.
//   a word with stream_end set marks the end of the file; it ends the parse
//   and rearms the parser for the next file (its data_byte is ignored).
//   the output channel moves at most one result word per file: either the
//   format fields with data chunk offset and size, or an error code.
//   after a result, further bytes are dropped until stream_end comes in.
// timing:
//   one input word per cycle sustained while no stall holds the flow; each byte takes one pass through the
//   next-state logic between the input register and the result register.
// reset:
//   arst_n clears both valid flags and returns the parser to the riff header
//   state with all captured fields at zero.
// stall:
//   a held result stays on the output; the input register still drains words
//   that make no result, and in_stall rises only when the next byte would make
//   a result while the output register is still occupied.
module wav_riff_header_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        stream_end,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        header_ok,
	output logic [1:0]  error_code,
	output logic [15:0] audio_format,
	output logic [15:0] channel_count,
	output logic [31:0] sample_rate,
	output logic [15:0] bits_per_sample,
	output logic [31:0] data_offset,
	output logic [31:0] data_size
);
	import wavp_pkg::*;

	in_item_t in_item;
	in_item_t item_s1;
	logic     valid_s1;
	logic     out_room;
	logic     emit;
	logic     consume;
	logic     s1_stall;
	result_t  result_d;
	result_t  result_q;

	assign in_item.data_byte  = data_byte;
	assign in_item.stream_end = stream_end;

	// a word leaves the input register unless it makes a result with no room
	assign consume  = valid_s1 && (out_room || !emit);
	assign s1_stall = !consume;

	wavp_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.advance  (!s1_stall),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	wavp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.consume (consume),
		.item    (item_s1),
		.emit    (emit),
		.result  (result_d)
	);

	wavp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (consume && emit),
		.result_in (result_d),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.result_q  (result_q),
		.advance   (out_room)
	);

	assign header_ok       = result_q.header_ok;
	assign error_code      = result_q.error_code;
	assign audio_format    = result_q.audio_format;
	assign channel_count   = result_q.channel_count;
	assign sample_rate     = result_q.sample_rate;
	assign bits_per_sample = result_q.bits_per_sample;
	assign data_offset     = result_q.data_offset;
	assign data_size       = result_q.data_size;

	// error results never carry a data chunk location
	a_err_no_loc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> !header_ok && data_offset == '0
			&& data_size == '0)
		else $error("error result carries data chunk fields");

	// a bad riff header can only occur before any fmt chunk was captured
	a_not_wave_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code == ERR_NOT_WAVE |-> audio_format == '0
			&& channel_count == '0 && sample_rate == '0 && bits_per_sample == '0)
		else $error("not-wave result with captured fmt fields");

	// input back-pressure only while the holding register has a word
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid)
		else $error("input stalled with nothing held");

endmodule

FILE: dv/wavp_checker.sv
// checker for the riff/wave header parser: byte-level parse prediction and result compare
`timescale 1ns / 100ps

module wavp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        stream_end,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        header_ok,
	input  logic [1:0]  error_code,
	input  logic [15:0] audio_format,
	input  logic [15:0] channel_count,
	input  logic [31:0] sample_rate,
	input  logic [15:0] bits_per_sample,
	input  logic [31:0] data_offset,
	input  logic [31:0] data_size,
	output int          fail_count,
	output int          results_pending
);
	import wavp_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_CHUNK  = 3'd1,
		PH_FMT    = 3'd2,
		PH_SKIP   = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	phase_t      phase;
	logic [4:0]  field_cnt;
	logic [31:0] skip_left;
	logic [31:0] stream_pos;
	logic [31:0] tag_acc;
	logic [31:0] len_acc;
	logic [15:0] fmt_tag;
	logic [15:0] fmt_channels;
	logic [31:0] fmt_rate;
	logic [15:0] fmt_bits;
	logic        fmt_seen;
	logic        pad_due;
	logic [15:0] stage_fmt;
	logic [15:0] stage_ch;
	logic [31:0] stage_rate;
	logic [15:0] stage_bits;

	result_t expected_reports[$];
	result_t want;
	int      mismatches = 0;

	assign fail_count = mismatches;

	function automatic void clear_parser();
		phase        = PH_HEADER;
		field_cnt    = '0;
		skip_left    = '0;
		stream_pos   = '0;
		tag_acc      = '0;
		len_acc      = '0;
		fmt_tag      = '0;
		fmt_channels = '0;
		fmt_rate     = '0;
		fmt_bits     = '0;
		fmt_seen     = 1'b0;
		pad_due      = 1'b0;
		stage_fmt    = '0;
		stage_ch     = '0;
		stage_rate   = '0;
		stage_bits   = '0;
	endfunction

	function automatic void post_report(logic ok, err_t err, logic [31:0] off, logic [31:0] size);
		result_t r;
		r.header_ok       = ok;
		r.error_code      = err;
		r.audio_format    = fmt_tag;
		r.channel_count   = fmt_channels;
		r.sample_rate     = fmt_rate;
		r.bits_per_sample = fmt_bits;
		r.data_offset     = off;
		r.data_size       = size;
		expected_reports.push_back(r);
		phase = PH_DONE;
	endfunction

	function automatic void enter_skip();
		phase     = (skip_left == 0 && !pad_due) ? PH_CHUNK : PH_SKIP;
		field_cnt = '0;
	endfunction

	function automatic void parse_file_byte(logic [7:0] b, logic is_end);
		logic [4:0] idx;
		if (is_end) begin
			if (phase != PH_DONE)
				post_report(1'b0, ERR_EARLY_END, '0, '0);
			clear_parser();
			return;
		end
		if (phase == PH_DONE)
			return;
		stream_pos = stream_pos + 32'd1;
		idx = field_cnt;
		case (phase)
			PH_HEADER: begin
				if (idx < 4)
					tag_acc = {b, tag_acc[31:8]};
				else if (idx >= 8)
					len_acc = {b, len_acc[31:8]};
				if (idx >= 11) begin
					field_cnt = '0;
					if (tag_acc != TAG_RIFF || len_acc != TAG_WAVE)
						post_report(1'b0, ERR_NOT_WAVE, '0, '0);
					else
						phase = PH_CHUNK;
				end else begin
					field_cnt = idx + 5'd1;
				end
			end
			PH_CHUNK: begin
				if (idx < 4)
					tag_acc = {b, tag_acc[31:8]};
				else
					len_acc = {b, len_acc[31:8]};
				if (idx < 7) begin
					field_cnt = idx + 5'd1;
				end else begin
					field_cnt = '0;
					if (tag_acc == TAG_FMT) begin
						if (len_acc < FMT_MIN) begin
							post_report(1'b0, ERR_FMT_SHORT, '0, '0);
						end else begin
							stage_fmt  = '0;
							stage_ch   = '0;
							stage_rate = '0;
							stage_bits = '0;
							phase      = PH_FMT;
						end
					end else if (tag_acc == TAG_DATA) begin
						post_report(fmt_seen, ERR_NONE, stream_pos, len_acc);
					end else begin
						skip_left = len_acc;
						pad_due   = len_acc[0];
						enter_skip();
					end
				end
			end
			PH_FMT: begin
				if (idx < 2)
					stage_fmt = {b, stage_fmt[15:8]};
				else if (idx < 4)
					stage_ch = {b, stage_ch[15:8]};
				else if (idx < 8)
					stage_rate = {b, stage_rate[31:8]};
				else if (idx >= 14)
					stage_bits = {b, stage_bits[15:8]};
				if (idx < 15) begin
					field_cnt = idx + 5'd1;
				end else begin
					// whole fmt body in: commit, then skip the extra bytes
					fmt_tag      = stage_fmt;
					fmt_channels = stage_ch;
					fmt_rate     = stage_rate;
					fmt_bits     = stage_bits;
					fmt_seen     = 1'b1;
					skip_left    = len_acc - FMT_MIN;
					pad_due      = len_acc[0];
					enter_skip();
				end
			end
			default: begin
				if (skip_left != 0)
					skip_left = skip_left - 32'd1;
				else
					pad_due = 1'b0;
				if (skip_left == 0 && !pad_due) begin
					phase     = PH_CHUNK;
					field_cnt = '0;
				end
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, actual %0h", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			expected_reports.delete();
			results_pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					$error("result word with no result expected");
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					check_field("header_ok", 32'(want.header_ok), 32'(header_ok));
					check_field("error_code", 32'(want.error_code), 32'(error_code));
					check_field("audio_format", 32'(want.audio_format),
						32'(audio_format));
					check_field("channel_count", 32'(want.channel_count),
						32'(channel_count));
					check_field("sample_rate", want.sample_rate, sample_rate);
					check_field("bits_per_sample", 32'(want.bits_per_sample),
						32'(bits_per_sample));
					check_field("data_offset", want.data_offset, data_offset);
					check_field("data_size", want.data_size, data_size);
				end
			end
			if (in_valid && !in_stall)
				parse_file_byte(data_byte, stream_end);
			results_pending <= expected_reports.size();
		end
	end

endmodule

FILE: dv/testbench.sv
// top of the riff/wave header parser testbench: file stimulus, stall control and verdict
`timescale 1ns / 100ps

module testbench;
	import wavp_pkg::*;

	// cycles with no word moving on either side before the run is called hung
	localparam int STUCK_LIMIT = 3000;
	// length of a long receiver hold-off, in cycles
	localparam int HOLD_CYCLES = 300;
	// input words for the whole run, and the point after which idling stops
	localparam int WORD_TARGET = 900;
	localparam int QUIET_FROM  = 750;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        stream_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        header_ok;
	logic [1:0]  error_code;
	logic [15:0] audio_format;
	logic [15:0] channel_count;
	logic [31:0] sample_rate;
	logic [15:0] bits_per_sample;
	logic [31:0] data_offset;
	logic [31:0] data_size;
	int          fail_count;
	int          results_pending;

	// stimulus controls
	logic        gaps_on = 1'b0;
	logic        quiet = 1'b0;
	logic        hold_request = 1'b0;
	int          words_sent = 0;
	int          stuck_cycles = 0;
	logic [7:0]  file_bytes[$];

	always #2 clk = ~clk;

	wav_riff_header_parser_top i_dut (.*);

	wavp_checker i_checker (.*);

	// watchdog: any word moving on either side resets the count
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// receiver side: random stall bursts, idle-free stretches, and the long hold-off
	// that lets the output register fill so the block has to stall its input
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_request = 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 29) == 0) begin
				// stretch with the receiver always ready
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end
		end
	end

	// zero and all-ones show up often so the field extremes get exercised
	function automatic logic [31:0] biased_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	task automatic put_le(input logic [31:0] v, input int nbytes);
		for (int k = 0; k < nbytes; k++)
			file_bytes.push_back(v[8*k +: 8]);
	endtask

	task automatic put_random(input int n);
		repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// riff tag, a size field that the parser ignores, wave tag
	task automatic put_header();
		put_le(TAG_RIFF, 4);
		put_le($urandom(), 4);
		put_le(TAG_WAVE, 4);
	endtask

	// fmt chunk; lengths past 63 only get a few extra bytes since the file is cut short anyway
	task automatic put_fmt(input logic [31:0] len, input logic [15:0] fmt,
			input logic [15:0] chans, input logic [31:0] rate, input logic [15:0] bits);
		put_le(TAG_FMT, 4);
		put_le(len, 4);
		if (len < FMT_MIN)
			return;
		put_le(32'(fmt), 2);
		put_le(32'(chans), 2);
		put_le(rate, 4);
		put_random(6);    // byte rate and block align, not captured
		put_le(32'(bits), 2);
		if (len < 64)
			put_random(len - 16 + len[0]);
		else
			put_random(5);
	endtask

	task automatic put_random_fmt(input logic [31:0] len);
		put_fmt(len, 16'(biased_value()), 16'(biased_value()), biased_value(),
			16'(biased_value()));
	endtask

	// some chunk to be skipped; tags one bit away from fmt and data check the compare
	task automatic put_other(input logic [31:0] len);
		logic [31:0] t;
		case ($urandom_range(0, 3))
			0: t = TAG_FMT ^ (32'd1 << $urandom_range(0, 31));
			1: t = TAG_DATA ^ (32'd1 << $urandom_range(0, 31));
			default: t = $urandom();
		endcase
		if (t == TAG_FMT || t == TAG_DATA)
			t = t ^ 32'h8000_0000;
		put_le(t, 4);
		put_le(len, 4);
		if (len < 64)
			put_random(len + len[0]);
		else
			put_random(5);
	endtask

	task automatic put_data(input logic [31:0] size);
		put_le(TAG_DATA, 4);
		put_le(size, 4);
	endtask

	task automatic cut_file(input int keep);
		while (file_bytes.size() > keep)
			void'(file_bytes.pop_back());
	endtask

	// one word on the input channel, with an occasional idle burst ahead of it
	task automatic push_word(input logic [7:0] b, input logic is_end);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		stream_end <= is_end;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
	endtask

	// the file bytes, then the end-of-stream word with a random don't-care byte
	task automatic send_file();
		gaps_on = !quiet && $urandom_range(0, 3) != 0;
		foreach (file_bytes[k])
			push_word(file_bytes[k], 1'b0);
		push_word(8'($urandom_range(0, 255)), 1'b1);
		file_bytes.delete();
	endtask

	task automatic make_random_file();
		int kind;
		int pos;
		kind = $urandom_range(0, 99);
		file_bytes.delete();
		if (kind < 60) begin
			// well-formed file; some are cut short at a random byte
			put_header();
			repeat ($urandom_range(0, 3)) begin
				if ($urandom_range(0, 2) == 0)
					put_random_fmt($urandom_range(16, 23));
				else
					put_other($urandom_range(0, 9));
			end
			if ($urandom_range(0, 9) != 0)
				put_random_fmt($urandom_range(16, 23));
			if ($urandom_range(0, 3) == 0)
				put_other($urandom_range(0, 9));
			put_data(biased_value());
			put_random($urandom_range(0, 4));
			if (kind >= 45)
				cut_file($urandom_range(0, file_bytes.size() - 1));
		end else if (kind < 70) begin
			// fmt chunk under the minimum size
			put_header();
			if ($urandom_range(0, 1) == 0)
				put_other($urandom_range(0, 5));
			put_random_fmt($urandom_range(0, 15));
			put_random($urandom_range(0, 6));
		end else if (kind < 80) begin
			// one bit wrong in the riff or wave tag
			put_header();
			put_random_fmt(16);
			put_data(biased_value());
			pos = $urandom_range(0, 7);
			if (pos >= 4)
				pos += 4;
			file_bytes[pos] ^= 8'(1 << $urandom_range(0, 7));
		end else if (kind < 90) begin
			// chunk far longer than the file, so the stream ends inside it
			put_header();
			if ($urandom_range(0, 1) == 0)
				put_random_fmt(biased_value() | 32'h40);
			else
				put_other(biased_value() | 32'h40);
		end else begin
			// noise, sometimes with a valid riff tag ahead of it
			if ($urandom_range(0, 1) == 0)
				put_le(TAG_RIFF, 4);
			put_random($urandom_range(0, 30));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// end of stream right out of reset: early end with empty fields
		send_file();
		// garbage header
		put_random(12);
		send_file();
		// all-ones fmt fields, largest data size
		put_header();
		put_fmt(16, '1, '1, '1, '1);
		put_data('1);
		send_file();
		// data chunk with no fmt ahead of it, zero size
		put_header();
		put_data('0);
		put_random(3);
		send_file();
		// fmt one byte short of the minimum
		put_header();
		put_fmt(15, '0, '0, '0, '0);
		send_file();
		// odd fmt length and odd skipped chunk, both with pad bytes
		put_header();
		put_fmt(17, 16'h0001, 16'h0002, 32'd44100, 16'd16);
		put_other(3);
		put_data(32'h0001_0000);
		send_file();
		// second fmt cut off mid-body: only the first one counts
		put_header();
		put_fmt(16, 16'h0003, 16'h0001, 32'd48000, 16'd24);
		put_fmt(20, 16'hFFFE, 16'h0006, 32'd96000, 16'd32);
		cut_file(50);
		send_file();

		// receiver holds off while short bad files keep coming, filling the output
		hold_request = 1'b1;
		repeat (6) begin
			put_random(12);
			send_file();
		end

		while (words_sent < WORD_TARGET) begin
			if (words_sent >= QUIET_FROM)
				quiet = 1'b1;
			if (words_sent >= WORD_TARGET / 2 && words_sent < WORD_TARGET / 2 + 60)
				hold_request = 1'b1;
			make_random_file();
			send_file();
		end
		in_valid <= 1'b0;

		// drain: let the checker take in the last accepted word, then wait out the pending results
		@(posedge clk);
		while (results_pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
